[rtl/core/qscs_pkg.sv]
package qscs_pkg;

    // Sequencer phase, encoded as reported on the result beat
    typedef enum logic [2:0] {
        PH_LOCKED   = 3'd0,
        PH_IDLE     = 3'd1,
        PH_PENDING  = 3'd2,
        PH_CUTTING  = 3'd3,
        PH_COOLDOWN = 3'd4
    } t_phase;

    // LED drive selection handed to the blink unit
    typedef enum logic [1:0] {
        LED_STEADY = 2'd0,
        LED_SLOW   = 2'd1,
        LED_FAST   = 2'd2
    } t_led_mode;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [1:0] CFG_MAX_CUT  = 2'd1;
    localparam logic [1:0] CFG_COOLDOWN = 2'd2;

    localparam int unsigned CFG_W = 16;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] MAX_CUT_RST  = 16'd150;
    localparam logic [CFG_W-1:0] COOLDOWN_RST = 16'd300;

    // Blink half periods in ms (1 Hz and 5 Hz)
    localparam logic [CFG_W-1:0] SLOW_BLINK_MS = 16'd500;
    localparam logic [CFG_W-1:0] FAST_BLINK_MS = 16'd100;

endpackage

[rtl/core/qscs_blink.sv]
module qscs_blink #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_tick,
    input  logic [TIME_WIDTH-1:0]   i_now,
    input  qscs_pkg::t_led_mode     i_mode,
    output logic                    o_led
);

    logic [TIME_WIDTH-1:0] r_last;
    logic                  r_level;
    logic [TIME_WIDTH-1:0] w_period;
    logic [TIME_WIDTH-1:0] w_elapsed;
    logic                  w_hit;
    logic                  w_blinking;

    always_comb begin
        w_blinking = 1'b1;
        w_period   = TIME_WIDTH'(qscs_pkg::SLOW_BLINK_MS);
        unique case (i_mode)
            qscs_pkg::LED_SLOW: w_period = TIME_WIDTH'(qscs_pkg::SLOW_BLINK_MS);
            qscs_pkg::LED_FAST: w_period = TIME_WIDTH'(qscs_pkg::FAST_BLINK_MS);
            qscs_pkg::LED_STEADY: w_blinking = 1'b0;
            default: w_blinking = 1'b0;
        endcase
    end

    assign w_elapsed = i_now - r_last;
    assign w_hit     = w_blinking && (w_elapsed >= w_period);
    assign o_led     = w_blinking ? (w_hit ? ~r_level : r_level) : 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_level <= 1'b0;
        end else if (i_tick && w_hit) begin
            r_last  <= i_now;
            r_level <= ~r_level;
        end
    end

endmodule

[rtl/core/quick_shift_cut_sequencer.sv]
// Quick-shift ignition cut sequencer.
// Input stream (s_axis): one beat per update tick carrying the ms timestamp,
// shift sensor flags, cut permission, neutral/rpm flags and cut length.
// Output stream (m_axis): one result beat per input beat with the cut line,
// LED level, phase code and the shift_done / forced_off pulses.
// Config channel (i_cfg_*): writes debounce, max cut and cooldown times;
// o_cfg_ready is always high, index 3 is ignored.
// Latency: the result beat is valid the cycle after the input beat is taken.
// Throughput: one beat per cycle. The whole tick step (phase step, elapsed
// time compares, blink update) is combinational from the input beat into
// the result register, and the state registers load on the same edge.
// Reset (i_rst_n low, synchronous): phase locked, timers and blink state
// zero, configuration at 20/150/300 ms, no result pending.
// Receiver stall: the result register holds; s_axis_tready stays high only
// while the result register is empty or being drained in the same cycle.
module quick_shift_cut_sequencer #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: now_ms[31:0], shift_pressed[32], shift_released[33],
    //        shift_allowed[34], neutral_seen[35], rpm_alive[36],
    //        cut_length_ms[52:37], zero pad [55:53]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    // tdata: cut_active[0], led_lit[1], phase[4:2], shift_done[5],
    //        forced_off[6], zero pad [7]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned CW = qscs_pkg::CFG_W;

    // Config registers
    logic [CW-1:0] r_debounce;
    logic [CW-1:0] r_max_cut;
    logic [CW-1:0] r_cooldown;

    // Sequencer state
    qscs_pkg::t_phase      r_phase, n_phase;
    logic [TIME_WIDTH-1:0] r_pend_start, n_pend_start;
    logic [TIME_WIDTH-1:0] r_cut_start, n_cut_start;
    logic [CW-1:0]         r_cut_len, n_cut_len;
    logic [TIME_WIDTH-1:0] r_cool_start, n_cool_start;
    logic                  r_need_rel, n_need_rel;

    // Result register
    logic       r_out_valid;
    logic [7:0] r_out_data;

    // Unpacked input beat
    logic [TIME_WIDTH-1:0] w_now;
    logic                  w_pressed, w_released, w_allowed, w_neutral, w_rpm_ok;
    logic [CW-1:0]         w_len_in;
    logic                  w_accept;

    // Tick step
    qscs_pkg::t_phase      w_phase_a;
    logic [TIME_WIDTH-1:0] w_cool_start_a;
    logic                  w_need_rel_a;
    logic [TIME_WIDTH-1:0] w_d_cut, w_d_pend, w_d_cool;
    logic                  w_overrun, w_cut_end, w_done;
    qscs_pkg::t_led_mode   w_led_mode;
    logic                  w_led;

    assign w_now      = TIME_WIDTH'(s_axis_tdata[31:0]);
    assign w_pressed  = s_axis_tdata[32];
    assign w_released = s_axis_tdata[33];
    assign w_allowed  = s_axis_tdata[34];
    assign w_neutral  = s_axis_tdata[35];
    assign w_rpm_ok   = s_axis_tdata[36];
    assign w_len_in   = s_axis_tdata[52:37];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Wrapping elapsed times
    assign w_d_cut  = w_now - r_cut_start;
    assign w_d_pend = w_now - r_pend_start;

    // Overrun check precedes the phase step
    assign w_overrun      = (r_phase == qscs_pkg::PH_CUTTING) &&
                            (w_d_cut > TIME_WIDTH'(r_max_cut));
    assign w_phase_a      = w_overrun ? qscs_pkg::PH_COOLDOWN : r_phase;
    assign w_cool_start_a = w_overrun ? w_now : r_cool_start;
    assign w_d_cool       = w_now - w_cool_start_a;
    assign w_need_rel_a   = r_need_rel && !w_released;
    assign w_cut_end      = w_d_cut >= TIME_WIDTH'(r_cut_len);

    // Next state
    always_comb begin
        n_phase      = w_phase_a;
        n_pend_start = r_pend_start;
        n_cut_start  = r_cut_start;
        n_cut_len    = r_cut_len;
        n_cool_start = w_cool_start_a;
        n_need_rel   = w_need_rel_a;
        unique case (w_phase_a)
            qscs_pkg::PH_IDLE: begin
                if (!w_need_rel_a && w_pressed && w_allowed) begin
                    n_phase      = qscs_pkg::PH_PENDING;
                    n_pend_start = w_now;
                end
            end
            qscs_pkg::PH_PENDING: begin
                if (!w_pressed) begin
                    n_phase = qscs_pkg::PH_IDLE;
                end else if (w_d_pend >= TIME_WIDTH'(r_debounce)) begin
                    if (!w_allowed) begin
                        n_phase = qscs_pkg::PH_IDLE;
                    end else begin
                        n_phase     = qscs_pkg::PH_CUTTING;
                        n_cut_len   = w_len_in;
                        n_cut_start = w_now;
                        n_need_rel  = 1'b1;
                    end
                end
            end
            qscs_pkg::PH_CUTTING: begin
                if (w_cut_end) begin
                    n_phase      = qscs_pkg::PH_COOLDOWN;
                    n_cool_start = w_now;
                end
            end
            qscs_pkg::PH_COOLDOWN: begin
                if (w_d_cool >= TIME_WIDTH'(r_cooldown)) begin
                    n_phase = qscs_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = w_neutral ? qscs_pkg::PH_IDLE : qscs_pkg::PH_LOCKED;
            end
        endcase
    end

    // Outputs of the step
    always_comb begin
        w_done = (w_phase_a == qscs_pkg::PH_CUTTING) && w_cut_end;
        if (n_phase == qscs_pkg::PH_CUTTING) begin
            w_led_mode = qscs_pkg::LED_STEADY;
        end else if (n_phase == qscs_pkg::PH_LOCKED) begin
            w_led_mode = qscs_pkg::LED_SLOW;
        end else if (!w_rpm_ok) begin
            w_led_mode = qscs_pkg::LED_FAST;
        end else begin
            w_led_mode = qscs_pkg::LED_STEADY;
        end
    end

    qscs_blink #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_blink (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (w_accept),
        .i_now   (w_now),
        .i_mode  (w_led_mode),
        .o_led   (w_led)
    );

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= qscs_pkg::DEBOUNCE_RST;
            r_max_cut  <= qscs_pkg::MAX_CUT_RST;
            r_cooldown <= qscs_pkg::COOLDOWN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qscs_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                qscs_pkg::CFG_MAX_CUT:  r_max_cut  <= i_cfg_data;
                qscs_pkg::CFG_COOLDOWN: r_cooldown <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // State update on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= qscs_pkg::PH_LOCKED;
            r_pend_start <= '0;
            r_cut_start  <= '0;
            r_cut_len    <= '0;
            r_cool_start <= '0;
            r_need_rel   <= 1'b0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_pend_start <= n_pend_start;
            r_cut_start  <= n_cut_start;
            r_cut_len    <= n_cut_len;
            r_cool_start <= n_cool_start;
            r_need_rel   <= n_need_rel;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {1'b0, w_overrun, w_done, 3'(n_phase), w_led,
                           (n_phase == qscs_pkg::PH_CUTTING)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // A cut never both completes and overruns on one tick
    a_done_xor_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !(w_done && w_overrun))
        else $error("shift_done and forced_off on the same tick");

    // Cutting is entered from pending only
    a_cut_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_phase == qscs_pkg::PH_CUTTING && r_phase != qscs_pkg::PH_CUTTING)
        |-> r_phase == qscs_pkg::PH_PENDING)
        else $error("cut started outside pending");

    // Release latch arms only together with a new cut
    a_need_rel_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_need_rel) |-> r_phase == qscs_pkg::PH_CUTTING)
        else $error("release latch set without a cut");

    // Every accepted beat yields a result beat on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("result beat missing after accept");
`endif

endmodule

[tb/sv/quick_shift_cut_sequencer_tb.sv]
module quick_shift_cut_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Register index 3 has no register behind it; writes to it must be dropped.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // One update tick as packed on s_axis_tdata[52:0], MSB first.
    typedef struct packed {
        logic [15:0] cut_len;
        logic        rpm_alive;
        logic        neutral_seen;
        logic        shift_allowed;
        logic        shift_released;
        logic        shift_pressed;
        logic [31:0] now_ms;
    } t_tick;

    // One result beat as packed on m_axis_tdata[6:0], MSB first.
    typedef struct packed {
        logic             forced_off;
        logic             shift_done;
        qscs_pkg::t_phase phase;
        logic             led_lit;
        logic             cut_active;
    } t_seq_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;   // now_ms, pressed, released, allowed, neutral, rpm, len
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // cut_active, led_lit, phase[2:0], done, forced_off, pad
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = qscs_pkg::CFG_DEBOUNCE;
    logic [15:0] i_cfg_data    = '0;

    quick_shift_cut_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 4 ns clock
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Sequencer shadow: timing registers and phase state, updated on every
    // accepted config beat and input beat.
    // ------------------------------------------------------------------
    logic [15:0] debounce_cfg;
    logic [15:0] max_cut_cfg;
    logic [15:0] cooldown_cfg;

    qscs_pkg::t_phase ph;
    logic [31:0] pend_t0;
    logic [31:0] cut_t0;
    logic [15:0] cut_len_q;
    logic [31:0] cool_t0;
    logic        must_release;
    logic [31:0] blink_t0;
    logic        blink_on;

    t_seq_result results_due[$];   // results owed by the block, oldest first
    int unsigned mismatches = 0;

    // Traffic shaping shared by the sender and the receiver
    bit          gaps_on   = 1'b1;
    int unsigned sink_hold = 0;    // long receiver hold-off, counted down by the sink
    int unsigned sink_wait = 0;    // short random receiver stall
    logic [31:0] stim_ms   = '0;   // running timestamp of the random stimulus

    // Elapsed ms with 32-bit wrap
    function automatic logic [31:0] ms_since(input logic [31:0] now, input logic [31:0] then);
        return now - then;
    endfunction

    // Toggle the LED once a half period has passed since the last toggle
    function automatic logic blink_step(input logic [31:0] now, input logic [15:0] half_ms);
        if (ms_since(now, blink_t0) >= 32'(half_ms)) begin
            blink_on = ~blink_on;
            blink_t0 = now;
        end
        return blink_on;
    endfunction

    // One update tick of the sequencer; returns the result beat it produces
    function automatic t_seq_result sequencer_step(input t_tick t);
        t_seq_result r;
        r = '0;

        if (must_release && t.shift_released)
            must_release = 1'b0;

        // hard limit is checked before the phase step, which then runs in cooldown
        if (ph == qscs_pkg::PH_CUTTING && ms_since(t.now_ms, cut_t0) > 32'(max_cut_cfg)) begin
            r.forced_off = 1'b1;
            cool_t0      = t.now_ms;
            ph           = qscs_pkg::PH_COOLDOWN;
        end

        case (ph)
            qscs_pkg::PH_IDLE: begin
                if (!must_release && t.shift_pressed && t.shift_allowed) begin
                    ph      = qscs_pkg::PH_PENDING;
                    pend_t0 = t.now_ms;
                end
            end
            qscs_pkg::PH_PENDING: begin
                if (!t.shift_pressed) begin
                    ph = qscs_pkg::PH_IDLE;
                end else if (ms_since(t.now_ms, pend_t0) >= 32'(debounce_cfg)) begin
                    if (!t.shift_allowed) begin
                        ph = qscs_pkg::PH_IDLE;
                    end else begin
                        cut_len_q    = t.cut_len;
                        cut_t0       = t.now_ms;
                        must_release = 1'b1;
                        ph           = qscs_pkg::PH_CUTTING;
                    end
                end
            end
            qscs_pkg::PH_CUTTING: begin
                if (ms_since(t.now_ms, cut_t0) >= 32'(cut_len_q)) begin
                    r.shift_done = 1'b1;
                    cool_t0      = t.now_ms;
                    ph           = qscs_pkg::PH_COOLDOWN;
                end
            end
            qscs_pkg::PH_COOLDOWN: begin
                if (ms_since(t.now_ms, cool_t0) >= 32'(cooldown_cfg))
                    ph = qscs_pkg::PH_IDLE;
            end
            default: begin
                ph = t.neutral_seen ? qscs_pkg::PH_IDLE : qscs_pkg::PH_LOCKED;
            end
        endcase

        // LED: lit while cutting (blink state frozen), slow blink when locked,
        // fast blink with rpm lost, steady otherwise
        if (ph == qscs_pkg::PH_CUTTING)
            r.led_lit = 1'b1;
        else if (ph == qscs_pkg::PH_LOCKED)
            r.led_lit = blink_step(t.now_ms, qscs_pkg::SLOW_BLINK_MS);
        else if (!t.rpm_alive)
            r.led_lit = blink_step(t.now_ms, qscs_pkg::FAST_BLINK_MS);
        else
            r.led_lit = 1'b1;

        r.cut_active = (ph == qscs_pkg::PH_CUTTING);
        r.phase      = ph;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [2:0] want,
                                        input logic [2:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: all handshakes sampled at the rising edge. Output beats are
    // checked before the input beat of the same edge is predicted, since
    // that input's result can only leave on a later edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_seq_result got;
        t_seq_result want;
        if (!i_rst_n) begin
            debounce_cfg = qscs_pkg::DEBOUNCE_RST;
            max_cut_cfg  = qscs_pkg::MAX_CUT_RST;
            cooldown_cfg = qscs_pkg::COOLDOWN_RST;
            ph           = qscs_pkg::PH_LOCKED;
            pend_t0      = '0;
            cut_t0       = '0;
            cut_len_q    = '0;
            cool_t0      = '0;
            must_release = 1'b0;
            blink_t0     = '0;
            blink_on     = 1'b0;
            results_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_seq_result'(m_axis_tdata[6:0]);
                if (results_due.size() == 0) begin
                    $error("result beat %h with nothing expected", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("cut_active", {2'b0, want.cut_active}, {2'b0, got.cut_active});
                    check_field("led_lit",    {2'b0, want.led_lit},    {2'b0, got.led_lit});
                    check_field("phase",      want.phase,              got.phase);
                    check_field("shift_done", {2'b0, want.shift_done}, {2'b0, got.shift_done});
                    check_field("forced_off", {2'b0, want.forced_off}, {2'b0, got.forced_off});
                    check_field("pad",        3'd0,                    {2'b0, m_axis_tdata[7]});
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    qscs_pkg::CFG_DEBOUNCE: debounce_cfg = i_cfg_data;
                    qscs_pkg::CFG_MAX_CUT:  max_cut_cfg  = i_cfg_data;
                    qscs_pkg::CFG_COOLDOWN: cooldown_cfg = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                results_due.push_back(sequencer_step(t_tick'(s_axis_tdata[52:0])));
        end
    end

    // ------------------------------------------------------------------
    // Traffic helpers
    // ------------------------------------------------------------------
    function automatic bit chance(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (!gaps_on || r < 65)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random stalls, plus the long hold-off when a test asks for one
    always @(negedge i_clk) begin
        if (sink_hold != 0) begin
            m_axis_tready <= 1'b0;
            sink_hold--;
        end else if (sink_wait != 0) begin
            m_axis_tready <= 1'b0;
            sink_wait--;
        end else begin
            m_axis_tready <= 1'b1;
            sink_wait = pick_gap();
        end
    end

    function automatic t_tick mk_tick(input logic [31:0] now, input logic pressed,
                                      input logic released, input logic allowed,
                                      input logic neutral, input logic rpm,
                                      input logic [15:0] len);
        t_tick t;
        t.now_ms         = now;
        t.shift_pressed  = pressed;
        t.shift_released = released;
        t.shift_allowed  = allowed;
        t.neutral_seen   = neutral;
        t.rpm_alive      = rpm;
        t.cut_len        = len;
        return t;
    endfunction

    // Entered and left just after a falling edge; tvalid stays high on exit so
    // back-to-back beats never drop it within a time step.
    task automatic send_tick(input t_tick t);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, t};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Stop offering beats and wait until every owed result has left the block
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);   // settling margin after the last result beat
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Drains the block first; the spare index gets junk every time
    task automatic load_timing(input logic [15:0] debounce, input logic [15:0] max_cut,
                               input logic [15:0] cooldown);
        wait_idle();
        write_reg(CFG_SPARE, 16'($urandom()));
        write_reg(qscs_pkg::CFG_DEBOUNCE, debounce);
        write_reg(qscs_pkg::CFG_MAX_CUT, max_cut);
        write_reg(qscs_pkg::CFG_COOLDOWN, cooldown);
        i_cfg_valid <= 1'b0;
    endtask

    // Random shift cycles: rest, press, hold through the cut, release. Timestamps
    // step by about `scale` ms with the odd long jump or wrap; ~10% pure noise.
    task automatic run_shifts(input int unsigned n_items, input int unsigned scale);
        int unsigned sent;
        int unsigned r;
        logic        rpm;
        logic [15:0] len;
        t_tick       t;
        sent = 0;
        while (sent < n_items) begin
            rpm = chance(75);
            r   = $urandom_range(99);
            if (r < 8)
                len = 16'd0;
            else if (r < 14)
                len = 16'hFFFF;
            else if (r < 80)
                len = 16'($urandom_range(0, (6 * scale > 65535) ? 65535 : 6 * scale));
            else
                len = 16'($urandom());
            for (int stage = 0; stage < 4; stage++) begin
                repeat ($urandom_range(1, (stage == 2) ? 8 : 4)) begin
                    r = $urandom_range(99);
                    if (r < 70)
                        stim_ms += $urandom_range(0, scale);
                    else if (r < 92)
                        stim_ms += $urandom_range(0, 4 * scale);
                    else if (r < 98)
                        stim_ms += $urandom_range(0, 140000);
                    else
                        stim_ms = $urandom();
                    t.now_ms = stim_ms;
                    case (stage)
                        0: begin
                            t.shift_pressed  = chance(5);
                            t.shift_released = chance(95);
                        end
                        1: begin
                            t.shift_pressed  = chance(95);
                            t.shift_released = chance(8);
                        end
                        2: begin
                            t.shift_pressed  = chance(70);
                            t.shift_released = chance(10);
                        end
                        default: begin
                            t.shift_pressed  = chance(10);
                            t.shift_released = chance(90);
                        end
                    endcase
                    t.shift_allowed = chance((stage == 1) ? 88 : 70);
                    t.neutral_seen  = chance(92);
                    t.rpm_alive     = chance(10) ? ~rpm : rpm;
                    t.cut_len       = chance(10) ? 16'($urandom()) : len;
                    if (chance(10))
                        t = {21'($urandom()), $urandom()};
                    send_tick(t);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Locked after reset: 1 Hz blink, shift ignored, neutral unlocks
    task automatic test_locked_blink();
        send_tick(mk_tick(32'd100,  1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'd0));
        send_tick(mk_tick(32'd600,  1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 16'd50));
        // rpm lost, still slow blink
        send_tick(mk_tick(32'd700,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0));
        send_tick(mk_tick(32'd1200, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'd0));
        send_tick(mk_tick(32'd1300, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0));
    endtask

    // Full cycle on reset timing: debounce, cut, done, cooldown, release lockout
    task automatic test_shift_cycle();
        send_tick(mk_tick(32'd1310, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'd40));
        send_tick(mk_tick(32'd1320, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'd40));
        // cut, length latched
        send_tick(mk_tick(32'd1330, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'd40));
        send_tick(mk_tick(32'd1370, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0));
        // idle but still held
        send_tick(mk_tick(32'd1700, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0));
        send_tick(mk_tick(32'd1720, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0));
    endtask

    // Overrun into zero cooldown, zero cut length, not allowed at debounce end,
    // fast blink, timestamp wrap with extreme field values
    task automatic test_corner_timing();
        load_timing(16'd0, 16'd10, 16'd0);
        send_tick(mk_tick(32'd2000, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'd100));
        send_tick(mk_tick(32'd2001, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'd100));
        // overrun, idle same tick
        send_tick(mk_tick(32'd2020, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'd100));
        // release and press together
        send_tick(mk_tick(32'd2030, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0));
        // zero-length cut
        send_tick(mk_tick(32'd2030, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0));
        send_tick(mk_tick(32'd2031, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0));
        // fast blink toggles
        send_tick(mk_tick(32'd2040, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0));
        send_tick(mk_tick(32'd2041, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0));
        // debounce done, not allowed
        send_tick(mk_tick(32'd2042, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0));
        send_tick(mk_tick(32'd2140, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0));
        send_tick(mk_tick(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'hFFFF));
        send_tick(mk_tick(32'h0000_0005, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'hFFFF));
        send_tick(mk_tick(32'h0000_0010, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0));
    endtask

    // Random shift traffic across several timing settings, extremes included
    task automatic test_random_shifts();
        int unsigned d;
        int unsigned m;
        int unsigned c;
        stim_ms = 32'h100;
        load_timing(qscs_pkg::DEBOUNCE_RST, qscs_pkg::MAX_CUT_RST, qscs_pkg::COOLDOWN_RST);
        run_shifts(300, 20);
        gaps_on = 1'b0;
        load_timing(16'd0, 16'd0, 16'd0);
        run_shifts(200, 3);
        gaps_on = 1'b1;
        load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_shifts(150, 16000);
        load_timing(16'd5, 16'd40, 16'd0);
        run_shifts(200, 8);
        gaps_on = 1'b0;
        load_timing(16'd0, 16'hFFFF, 16'd10);
        run_shifts(150, 200);
        gaps_on = 1'b1;
        repeat (3) begin
            d = $urandom_range(0, 500);
            m = $urandom_range(0, 500);
            c = $urandom_range(0, 500);
            load_timing(16'(d), 16'(m), 16'(c));
            run_shifts(150, 1 + (d + m + c) / 8);
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the result
    // register fills and tready drops; then the sender waits for a full drain
    task automatic test_backpressure();
        load_timing(qscs_pkg::DEBOUNCE_RST, qscs_pkg::MAX_CUT_RST, qscs_pkg::COOLDOWN_RST);
        gaps_on   = 1'b0;
        sink_hold = 150;
        run_shifts(40, 20);
        wait_idle();
        gaps_on = 1'b1;
        run_shifts(20, 20);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_locked_blink();
        test_shift_cycle();
        test_corner_timing();
        test_random_shifts();
        test_backpressure();
        wait_idle();
        repeat (16) @(negedge i_clk);   // catch stray beats after the drain
        if (mismatches == 0)
            $display("quick_shift_cut_sequencer: match");
        else
            $display("quick_shift_cut_sequencer: mismatch");
        $finish;
    end

    // Hang guard: several times the slowest legal run
    initial begin
        #4_000_000;
        $display("quick_shift_cut_sequencer: mismatch");
        $finish;
    end

endmodule
